[rtl/core/opl_pkg.sv]
package opl_pkg;

    // Default sizes of the overstrike store.
    localparam int LAYERS_DEF     = 10;
    localparam int LINE_WIDTH_DEF = 132;

    // Output buffer: bytes one input item may cause, and bytes per result.
    localparam int RESULT_BYTES = 32;
    localparam int OUT_CAP      = 48 * RESULT_BYTES;

    // Byte codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RESET  = 8'h63;
    localparam logic [7:0] CH_FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    localparam logic [9:0] TAB_MASK      = 10'd7;
    localparam logic [9:0] COL_MAX       = 10'd1023;
    localparam logic [7:0] FF_PAGE_LIMIT = 8'd66;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PAGE_LENGTH = 2'd1;
    localparam logic [1:0] REG_INDENT      = 2'd2;
    localparam logic [1:0] REG_LITERAL     = 2'd3;

    localparam logic [7:0] LINE_WIDTH_RST  = 8'd80;
    localparam logic [7:0] PAGE_LENGTH_RST = 8'd66;

    // Escape handler modes.
    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_START  = 2'd1;
    localparam logic [1:0] ESC_STRING = 2'd2;
    localparam logic [1:0] ESC_SEQ    = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LATCH,
        OP_DECODE,
        OP_PUT_CH,
        OP_SRCH_RD,
        OP_SRCH_CHK,
        OP_FL_CHK,
        OP_FL_RD,
        OP_FL_WR,
        OP_FL_TERM,
        OP_PUT_FF,
        OP_END_FF,
        OP_PUT_ESC,
        OP_END_C,
        OP_OUT_RD,
        OP_OUT_GET,
        OP_OUT_ACK
    } t_op;

    typedef enum logic [2:0] {
        K_NONE,
        K_ESC2,
        K_PLACE,
        K_FLUSH,
        K_END
    } t_kind;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  clr_done;
        logic  found;
        logic  srch_last;
        logic  fl_more;
        logic  c_lt_ext;
        logic  page_ff;
        logic  eoi;
        logic  deep_nz;
        logic  olen_nz;
        logic  j_full;
        logic  o_more;
    } t_status;

endpackage

[rtl/core/overstrike_print_line_filter.sv]
// Steps: a plain byte is latched and decoded; a placed byte reads and checks each
// overstrike row probed, and a line flush reads, sends and clears each stored character
// and ends each row with its terminator. Results are gathered byte by byte from the output buffer.
// Flow: one item at a time; the next item is taken once its last result is gone.
// Reset (synchronous, active low) starts a clearing pass over the overstrike store;
// no item is taken until it ends.
module overstrike_print_line_filter #(
    parameter int LAYERS     = opl_pkg::LAYERS_DEF,
    parameter int LINE_WIDTH = opl_pkg::LINE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port; the index selects the register.
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [7:0]   i_cfg_wdata,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  logic         s_axis_tlast,   // end_of_input
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [279:0] m_axis_tdata,   // [255:0] bytes_0_7..bytes_24_31,
                                         // [261:256] byte_count, [277:262] pages_done
    output logic         m_axis_tlast    // last_of_run
);

    opl_pkg::t_cmd    w_cmd;
    opl_pkg::t_status w_st;
    logic [255:0]     w_acc;
    logic [5:0]       w_cnt;
    logic [15:0]      w_pages;

    // The controller sequences the work of one item; the datapath holds the
    // overstrike store, the output buffer and all line and page state.
    opl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_st        (w_st),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    opl_dp #(
        .LAYERS     (LAYERS),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_byte      (s_axis_tdata),
        .i_eoi       (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_st        (w_st),
        .o_acc       (w_acc),
        .o_cnt       (w_cnt),
        .o_last      (m_axis_tlast),
        .o_pages     (w_pages)
    );

    // The result word: the gathered bytes, their count and the page count.
    assign m_axis_tdata = {2'b0, w_pages, w_cnt, w_acc};

`ifndef SYNTHESIS
    // Only one item is in work, so the block never takes input while a result is shown.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // A result always carries between one and a full word of bytes.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_cnt != 6'd0) && (w_cnt <= 6'(opl_pkg::RESULT_BYTES)))
        else $error("result byte count out of range");

    // Every result but the last of a run is full.
    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (w_cnt == 6'(opl_pkg::RESULT_BYTES)))
        else $error("short result before the end of a run");
`endif

endmodule

[rtl/core/opl_ctrl.sv]
module opl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  opl_pkg::t_status i_st,
    output opl_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_ESC2, S_SRD, S_SCHK,
        S_FCHK, S_FCOL, S_FRD, S_FWR, S_FTERM, S_FFF,
        S_EFF, S_EESC, S_EC, S_OCHK, S_ORD, S_OGET, S_OSEND
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_st.clr_done) r_state <= S_IDLE;
                S_IDLE:  if (i_in_valid) r_state <= S_DEC;
                S_DEC: begin
                    unique case (i_st.kind)
                        opl_pkg::K_END:   r_state <= i_st.deep_nz ? S_FCHK : S_EFF;
                        opl_pkg::K_FLUSH: r_state <= S_FCHK;
                        opl_pkg::K_PLACE: r_state <= S_SRD;
                        opl_pkg::K_ESC2:  r_state <= S_ESC2;
                        default:          r_state <= S_OCHK;
                    endcase
                end
                S_ESC2: r_state <= S_OCHK;
                S_SRD:  r_state <= S_SCHK;
                S_SCHK: r_state <= (i_st.found || i_st.srch_last) ? S_OCHK : S_SRD;
                S_FCHK: begin
                    if (i_st.fl_more) r_state <= S_FCOL;
                    else r_state <= i_st.eoi ? S_EFF : S_OCHK;
                end
                S_FCOL:  r_state <= i_st.c_lt_ext ? S_FRD : S_FTERM;
                S_FRD:   r_state <= S_FWR;
                S_FWR:   r_state <= S_FCOL;
                S_FTERM: r_state <= i_st.page_ff ? S_FFF : S_FCHK;
                S_FFF:   r_state <= S_FCHK;
                S_EFF:   r_state <= S_EESC;
                S_EESC:  r_state <= S_EC;
                S_EC:    r_state <= S_OCHK;
                S_OCHK:  r_state <= i_st.olen_nz ? S_ORD : S_IDLE;
                S_ORD:   r_state <= (i_st.j_full || !i_st.o_more) ? S_OSEND : S_OGET;
                S_OGET:  r_state <= S_ORD;
                S_OSEND: begin
                    if (i_out_ready) r_state <= i_st.o_more ? S_ORD : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_CLEAR: o_cmd.op = opl_pkg::OP_CLEAR;
            S_IDLE:  o_cmd.op = i_in_valid ? opl_pkg::OP_LATCH : opl_pkg::OP_NOP;
            S_DEC:   o_cmd.op = opl_pkg::OP_DECODE;
            S_ESC2:  o_cmd.op = opl_pkg::OP_PUT_CH;
            S_SRD:   o_cmd.op = opl_pkg::OP_SRCH_RD;
            S_SCHK:  o_cmd.op = opl_pkg::OP_SRCH_CHK;
            S_FCHK:  o_cmd.op = opl_pkg::OP_FL_CHK;
            S_FRD:   o_cmd.op = opl_pkg::OP_FL_RD;
            S_FWR:   o_cmd.op = opl_pkg::OP_FL_WR;
            S_FTERM: o_cmd.op = opl_pkg::OP_FL_TERM;
            S_FFF:   o_cmd.op = opl_pkg::OP_PUT_FF;
            S_EFF:   o_cmd.op = opl_pkg::OP_END_FF;
            S_EESC:  o_cmd.op = opl_pkg::OP_PUT_ESC;
            S_EC:    o_cmd.op = opl_pkg::OP_END_C;
            S_ORD:   o_cmd.op = opl_pkg::OP_OUT_RD;
            S_OGET:  o_cmd.op = opl_pkg::OP_OUT_GET;
            S_OSEND: o_cmd.op = i_out_ready ? opl_pkg::OP_OUT_ACK : opl_pkg::OP_NOP;
            default: o_cmd.op = opl_pkg::OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OSEND);

endmodule

[rtl/core/opl_dp.sv]
module opl_dp #(
    parameter int LAYERS     = opl_pkg::LAYERS_DEF,
    parameter int LINE_WIDTH = opl_pkg::LINE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  opl_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [7:0]       i_cfg_wdata,
    output opl_pkg::t_status o_st,
    output logic [255:0]     o_acc,
    output logic [5:0]       o_cnt,
    output logic             o_last,
    output logic [15:0]      o_pages
);

    localparam int RW    = $clog2(LAYERS + 1);
    localparam int RIW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int EW    = $clog2(LINE_WIDTH + 1);
    localparam int CW    = $clog2(LINE_WIDTH);
    localparam int DEPTH = LAYERS * LINE_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(opl_pkg::OUT_CAP + 1);
    localparam int OIW   = $clog2(opl_pkg::OUT_CAP);

    // Configuration.
    logic [7:0] r_lw, r_pl, r_ind;
    logic       r_lit;

    // Line state.
    logic [7:0]    r_byte;
    logic          r_eoi;
    logic [9:0]    r_col;
    logic [RW-1:0] r_deep;
    logic [RW-1:0] r_r;
    logic [EW-1:0] r_c;
    logic [EW-1:0] r_ext [LAYERS];
    logic [7:0]    r_lop;
    logic [15:0]   r_pages;
    logic [1:0]    r_esc;
    logic [7:0]    r_psb;
    logic          r_skip;
    logic [7:0]    r_term;
    logic [AW-1:0] r_clr;

    // Stores.
    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [7:0]    obuf [opl_pkg::OUT_CAP];
    logic [7:0]    r_odata;
    logic [OW-1:0] r_olen;
    logic [OW-1:0] r_p;
    logic [5:0]    r_j;
    logic [255:0]  r_acc;

    logic [RIW-1:0] w_ri;
    logic [AW-1:0]  w_addr;
    logic [7:0]     w_wdata;
    logic           w_we;
    logic           w_rd;
    logic           w_put;
    logic [7:0]     w_pdata;
    logic [9:0]     w_limit;
    logic           w_ctrl;
    logic           w_elig;
    logic           w_skipbyte;
    logic           w_escpath;
    logic [10:0]    w_col1;
    logic [9:0]     w_col_adv;
    logic [9:0]     w_tab_d;
    logic [10:0]    w_tab_to;
    logic [9:0]     w_tab_col;
    logic [8:0]     w_lop1;
    logic           w_page_end;
    logic           w_final;
    logic [10:0]    w_ext_new;

    assign w_ri = r_r[RIW-1:0];

    always_comb begin
        w_limit    = ({2'b0, r_lw} < 10'(LINE_WIDTH)) ? {2'b0, r_lw} : 10'(LINE_WIDTH);
        w_ctrl     = (r_byte < opl_pkg::CH_SPACE) || (r_byte >= opl_pkg::CH_HIGH);
        w_elig     = (r_col < w_limit) && !(w_ctrl && !r_lit);
        w_skipbyte = r_skip && ((r_byte == opl_pkg::CH_FF) || (r_byte == opl_pkg::CH_NUL));
        w_escpath  = (r_esc != opl_pkg::ESC_IDLE) || (r_byte == opl_pkg::CH_ESC);
        w_col1     = {1'b0, r_col} + 11'd1;
        w_col_adv  = (w_col1 > {1'b0, opl_pkg::COL_MAX}) ? opl_pkg::COL_MAX : w_col1[9:0];
        w_tab_d    = (r_col >= {2'b0, r_ind}) ? (r_col - {2'b0, r_ind}) : 10'd0;
        w_tab_to   = {1'b0, w_tab_d | opl_pkg::TAB_MASK} + {3'b0, r_ind} + 11'd1;
        w_tab_col  = (w_tab_to > {1'b0, opl_pkg::COL_MAX}) ? opl_pkg::COL_MAX : w_tab_to[9:0];
        w_lop1     = {1'b0, r_lop} + 9'd1;
        w_page_end = (w_lop1 >= {1'b0, r_pl});
        w_final    = (r_byte != opl_pkg::CH_UPPER_P) && (r_byte != opl_pkg::CH_BRACKET)
                     && (r_byte >= opl_pkg::CH_FINAL_LO) && (r_byte <= opl_pkg::CH_FINAL_HI);
        w_ext_new  = {1'b0, r_col} + 11'd1;
    end

    // Decode of the latched byte, and the status flags for the controller.
    always_comb begin
        if (r_eoi) begin
            o_st.kind = opl_pkg::K_END;
        end else if (w_skipbyte) begin
            o_st.kind = opl_pkg::K_NONE;
        end else if (w_escpath) begin
            o_st.kind = (r_esc == opl_pkg::ESC_START) ? opl_pkg::K_ESC2 : opl_pkg::K_NONE;
        end else if ((r_byte == opl_pkg::CH_FF) || (r_byte == opl_pkg::CH_NL)) begin
            o_st.kind = opl_pkg::K_FLUSH;
        end else if ((r_byte == opl_pkg::CH_BS) || (r_byte == opl_pkg::CH_CR)
                     || (r_byte == opl_pkg::CH_TAB)) begin
            o_st.kind = opl_pkg::K_NONE;
        end else begin
            o_st.kind = w_elig ? opl_pkg::K_PLACE : opl_pkg::K_NONE;
        end
        o_st.clr_done  = (r_clr == AW'(DEPTH - 1));
        o_st.found     = (r_rdata == opl_pkg::CH_SPACE);
        o_st.srch_last = (r_r == RW'(LAYERS - 1));
        o_st.fl_more   = (r_r < r_deep);
        o_st.c_lt_ext  = (r_c < r_ext[w_ri]);
        o_st.page_ff   = w_page_end && (r_pl < opl_pkg::FF_PAGE_LIMIT);
        o_st.eoi       = r_eoi;
        o_st.deep_nz   = (r_deep != '0);
        o_st.olen_nz   = (r_olen != '0);
        o_st.j_full    = (r_j == 6'(opl_pkg::RESULT_BYTES));
        o_st.o_more    = (r_p < r_olen);
    end

    // Store port and output buffer byte selection.
    always_comb begin
        w_we    = 1'b0;
        w_rd    = 1'b0;
        w_wdata = opl_pkg::CH_SPACE;
        w_addr  = AW'(w_ri) * AW'(LINE_WIDTH) + AW'(r_col[CW-1:0]);
        w_put   = 1'b0;
        w_pdata = r_byte;
        unique case (i_cmd.op)
            opl_pkg::OP_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr;
            end
            opl_pkg::OP_DECODE: begin
                if (!r_eoi && !w_skipbyte && w_escpath) begin
                    if (r_esc == opl_pkg::ESC_START) begin
                        w_put   = 1'b1;
                        w_pdata = opl_pkg::CH_ESC;
                    end else if (r_esc != opl_pkg::ESC_IDLE) begin
                        w_put = 1'b1;
                    end
                end
            end
            opl_pkg::OP_PUT_CH:  w_put = 1'b1;
            opl_pkg::OP_SRCH_RD: w_rd = 1'b1;
            opl_pkg::OP_SRCH_CHK: begin
                w_we    = o_st.found;
                w_wdata = r_byte;
            end
            opl_pkg::OP_FL_RD: begin
                w_rd   = 1'b1;
                w_addr = AW'(w_ri) * AW'(LINE_WIDTH) + AW'(r_c[CW-1:0]);
            end
            opl_pkg::OP_FL_WR: begin
                w_we    = 1'b1;
                w_addr  = AW'(w_ri) * AW'(LINE_WIDTH) + AW'(r_c[CW-1:0]);
                w_put   = 1'b1;
                w_pdata = r_rdata;
            end
            opl_pkg::OP_FL_TERM: begin
                w_put   = 1'b1;
                w_pdata = ((r_r + RW'(1)) < r_deep) ? opl_pkg::CH_CR : r_term;
            end
            opl_pkg::OP_PUT_FF: begin
                w_put   = 1'b1;
                w_pdata = opl_pkg::CH_FF;
            end
            opl_pkg::OP_END_FF: begin
                w_put   = (r_lop != 8'd0);
                w_pdata = opl_pkg::CH_FF;
            end
            opl_pkg::OP_PUT_ESC: begin
                w_put   = 1'b1;
                w_pdata = opl_pkg::CH_ESC;
            end
            opl_pkg::OP_END_C: begin
                w_put   = 1'b1;
                w_pdata = opl_pkg::CH_RESET;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_addr] <= w_wdata;
        if (w_rd) r_rdata <= mem[w_addr];
        if (w_put && (r_olen < OW'(opl_pkg::OUT_CAP))) obuf[r_olen[OIW-1:0]] <= w_pdata;
        if (i_cmd.op == opl_pkg::OP_OUT_RD) r_odata <= obuf[r_p[OIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw    <= opl_pkg::LINE_WIDTH_RST;
            r_pl    <= opl_pkg::PAGE_LENGTH_RST;
            r_ind   <= 8'd0;
            r_lit   <= 1'b0;
            r_col   <= 10'd0;
            r_deep  <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_lop   <= 8'd0;
            r_pages <= 16'd0;
            r_esc   <= opl_pkg::ESC_IDLE;
            r_psb   <= 8'd0;
            r_skip  <= 1'b1;
            r_clr   <= '0;
            r_olen  <= '0;
            r_p     <= '0;
            r_j     <= 6'd0;
            r_eoi   <= 1'b0;
            for (int i = 0; i < LAYERS; i++) r_ext[i] <= '0;
        end else begin
            if (w_put && (r_olen < OW'(opl_pkg::OUT_CAP))) r_olen <= r_olen + OW'(1);
            unique case (i_cmd.op)
                opl_pkg::OP_CLEAR: r_clr <= r_clr + AW'(1);
                opl_pkg::OP_LATCH: begin
                    r_byte <= i_byte;
                    r_eoi  <= i_eoi;
                    r_olen <= '0;
                    r_p    <= '0;
                    r_j    <= 6'd0;
                    r_acc  <= '0;
                end
                opl_pkg::OP_DECODE: begin
                    r_r <= '0;
                    if (r_eoi) begin
                        r_term <= opl_pkg::CH_NL;
                    end else if (!w_skipbyte) begin
                        r_skip <= 1'b0;
                        if (w_escpath) begin
                            unique case (r_esc)
                                opl_pkg::ESC_IDLE: r_esc <= opl_pkg::ESC_START;
                                opl_pkg::ESC_START: begin
                                    if (r_byte == opl_pkg::CH_UPPER_P) begin
                                        r_esc <= opl_pkg::ESC_STRING;
                                        r_psb <= r_byte;
                                    end else begin
                                        r_esc <= opl_pkg::ESC_SEQ;
                                    end
                                end
                                opl_pkg::ESC_STRING: begin
                                    if ((r_psb == opl_pkg::CH_ESC)
                                        && (r_byte == opl_pkg::CH_BSLASH)) begin
                                        r_esc <= opl_pkg::ESC_IDLE;
                                        r_psb <= 8'd0;
                                    end else begin
                                        r_psb <= r_byte;
                                    end
                                end
                                default: if (w_final) r_esc <= opl_pkg::ESC_IDLE;
                            endcase
                        end else if ((r_byte == opl_pkg::CH_FF)
                                     || (r_byte == opl_pkg::CH_NL)) begin
                            if (r_byte == opl_pkg::CH_FF) r_lop <= r_pl;
                            if (r_deep == '0) r_deep <= RW'(1);
                            r_term <= r_byte;
                        end else if (r_byte == opl_pkg::CH_BS) begin
                            r_col <= (r_col <= {2'b0, r_ind}) ? {2'b0, r_ind} : r_col - 10'd1;
                        end else if (r_byte == opl_pkg::CH_CR) begin
                            r_col <= {2'b0, r_ind};
                        end else if (r_byte == opl_pkg::CH_TAB) begin
                            r_col <= w_tab_col;
                        end else if (!w_elig) begin
                            r_col <= w_col_adv;
                        end
                    end
                end
                opl_pkg::OP_SRCH_RD: begin
                    if ((r_r + RW'(1)) > r_deep) r_deep <= r_r + RW'(1);
                end
                opl_pkg::OP_SRCH_CHK: begin
                    if (o_st.found) begin
                        if (w_ext_new[EW-1:0] > r_ext[w_ri]) r_ext[w_ri] <= w_ext_new[EW-1:0];
                        r_col <= w_col_adv;
                    end else if (o_st.srch_last) begin
                        r_col <= w_col_adv;
                    end else begin
                        r_r <= r_r + RW'(1);
                    end
                end
                opl_pkg::OP_FL_CHK: begin
                    r_c <= '0;
                    if (!o_st.fl_more) begin
                        r_deep <= '0;
                        r_col  <= {2'b0, r_ind};
                    end
                end
                opl_pkg::OP_FL_WR: r_c <= r_c + EW'(1);
                opl_pkg::OP_FL_TERM: begin
                    if (w_page_end) begin
                        r_pages <= r_pages + 16'd1;
                        r_lop   <= 8'd0;
                    end else begin
                        r_lop <= w_lop1[7:0];
                    end
                    r_ext[w_ri] <= '0;
                    r_r         <= r_r + RW'(1);
                end
                opl_pkg::OP_END_FF: begin
                    if (r_lop != 8'd0) r_pages <= r_pages + 16'd1;
                end
                opl_pkg::OP_END_C: begin
                    r_lop  <= 8'd0;
                    r_esc  <= opl_pkg::ESC_IDLE;
                    r_psb  <= 8'd0;
                    r_skip <= 1'b1;
                    r_col  <= {2'b0, r_ind};
                end
                opl_pkg::OP_OUT_GET: begin
                    r_acc[r_j[4:0] * 8 +: 8] <= r_odata;
                    r_j <= r_j + 6'd1;
                    r_p <= r_p + OW'(1);
                end
                opl_pkg::OP_OUT_ACK: begin
                    r_acc <= '0;
                    r_j   <= 6'd0;
                end
                default: begin
                    r_c <= r_c;
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    opl_pkg::REG_LINE_WIDTH:  r_lw <= i_cfg_wdata;
                    opl_pkg::REG_PAGE_LENGTH: r_pl <= i_cfg_wdata;
                    opl_pkg::REG_INDENT: begin
                        r_ind <= i_cfg_wdata;
                        r_col <= {2'b0, i_cfg_wdata};
                    end
                    default: r_lit <= i_cfg_wdata[0];
                endcase
            end
        end
    end

    assign o_acc   = r_acc;
    assign o_cnt   = r_j;
    assign o_last  = (r_p == r_olen);
    assign o_pages = r_pages;

endmodule

[sim/tb_overstrike_print_line_filter.sv]
`timescale 1ns / 100ps

module tb_overstrike_print_line_filter;

    // The run stops here if the block hangs. The slowest items are full flushes of
    // every overstrike row and items of 48 results under long receiver gaps.
    localparam int CYCLE_LIMIT = 20_000_000;
    // Quiet time before a register write, covering an item that sends nothing.
    localparam int SETTLE_CYCLES = 64;
    localparam int RAND_PHASES = 3;
    localparam int ITEMS_PER_PHASE = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [7:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] in_byte
    logic         s_axis_tlast;   // end_of_input
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [279:0] m_axis_tdata;   // [255:0] output bytes, [261:256] byte_count,
                                  // [277:262] pages_done
    logic         m_axis_tlast;   // last_of_run

    overstrike_print_line_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // One expected output chunk of up to 32 printer bytes.
    typedef struct {
        logic [255:0] bytes;
        logic [5:0]   count;
        logic         last;
        logic [15:0]  pages;
    } t_chunk;

    // One input byte of the text stream, or the end marker.
    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_text_item;

    // A row of the directed table. When known is set, the single chunk that the
    // row causes is typed in here instead of taken from the printer model.
    typedef struct {
        logic [7:0]   data;
        logic         eos;
        logic         known;
        logic [255:0] exp_bytes;
        logic [5:0]   exp_count;
        logic [15:0]  exp_pages;
    } t_table_row;

    t_chunk     pending_chunks[$];
    t_text_item text_q[$];
    logic [7:0] printer_bytes[$];

    int errors;
    int items_sent;
    int chunks_seen;
    int cycles;
    bit no_idle;

    // Shadow state of the printer filter.
    logic [7:0]  shadow_rows[opl_pkg::LAYERS_DEF][opl_pkg::LINE_WIDTH_DEF];
    int          row_len[opl_pkg::LAYERS_DEF];
    int          column;
    int          rows_used;
    int          line_no;
    logic [15:0] page_no;
    logic [1:0]  esc_state;
    logic [7:0]  prev_str;
    bit          lead_skip;
    int          width_cfg;
    int          plen_cfg;
    int          indent_cfg;
    bit          literal_cfg;

    // ---------------------------------------------------------------- printer model

    function automatic void put_byte(logic [7:0] b);
        if (printer_bytes.size() < opl_pkg::OUT_CAP)
            printer_bytes.push_back(b);
    endfunction

    function automatic void move_to(int to);
        column = (to > int'(opl_pkg::COL_MAX)) ? int'(opl_pkg::COL_MAX) : to;
    endfunction

    function automatic void count_line();
        line_no++;
        if (line_no >= plen_cfg) begin
            page_no = page_no + 16'd1;
            line_no = 0;
            if (plen_cfg < int'(opl_pkg::FF_PAGE_LIMIT))
                put_byte(opl_pkg::CH_FF);
        end
    endfunction

    // Sends every used overstrike row; rows are joined by CR and the last one
    // carries the terminating byte.
    function automatic void print_line(logic [7:0] term);
        for (int r = 0; r < rows_used && r < opl_pkg::LAYERS_DEF; r++) begin
            for (int c = 0; c < row_len[r] && c < opl_pkg::LINE_WIDTH_DEF; c++) begin
                put_byte(shadow_rows[r][c]);
                shadow_rows[r][c] = opl_pkg::CH_SPACE;
            end
            put_byte((r + 1 < rows_used) ? opl_pkg::CH_CR : term);
            count_line();
            row_len[r] = 0;
        end
        rows_used = 0;
        column = indent_cfg;
    endfunction

    function automatic void strike(logic [7:0] ch);
        int  limit;
        bit  ctrl;
        limit = (width_cfg < opl_pkg::LINE_WIDTH_DEF) ? width_cfg : opl_pkg::LINE_WIDTH_DEF;
        ctrl = (ch < opl_pkg::CH_SPACE) || (ch >= opl_pkg::CH_HIGH);
        if (column < limit && !(ctrl && !literal_cfg)) begin
            for (int r = 0; r < opl_pkg::LAYERS_DEF; r++) begin
                if (r + 1 > rows_used)
                    rows_used = r + 1;
                if (shadow_rows[r][column] == opl_pkg::CH_SPACE) begin
                    shadow_rows[r][column] = ch;
                    if (column + 1 > row_len[r])
                        row_len[r] = column + 1;
                    break;
                end
            end
        end
        move_to(column + 1);
    endfunction

    function automatic void escape_step(logic [7:0] ch);
        case (esc_state)
            opl_pkg::ESC_IDLE: begin
                esc_state = opl_pkg::ESC_START;
            end
            opl_pkg::ESC_START: begin
                put_byte(opl_pkg::CH_ESC);
                put_byte(ch);
                if (ch == opl_pkg::CH_UPPER_P) begin
                    esc_state = opl_pkg::ESC_STRING;
                    prev_str = ch;
                end else begin
                    esc_state = opl_pkg::ESC_SEQ;
                end
            end
            opl_pkg::ESC_STRING: begin
                if (prev_str == opl_pkg::CH_ESC && ch == opl_pkg::CH_BSLASH) begin
                    esc_state = opl_pkg::ESC_IDLE;
                    prev_str = 8'd0;
                end else begin
                    prev_str = ch;
                end
                put_byte(ch);
            end
            default: begin
                if (ch != opl_pkg::CH_UPPER_P && ch != opl_pkg::CH_BRACKET &&
                    ch >= opl_pkg::CH_FINAL_LO && ch <= opl_pkg::CH_FINAL_HI)
                    esc_state = opl_pkg::ESC_IDLE;
                put_byte(ch);
            end
        endcase
    endfunction

    function automatic void text_step(logic [7:0] ch);
        int d;
        if (lead_skip) begin
            if (ch == opl_pkg::CH_FF || ch == opl_pkg::CH_NUL)
                return;
            lead_skip = 0;
        end
        if (esc_state != opl_pkg::ESC_IDLE || ch == opl_pkg::CH_ESC) begin
            escape_step(ch);
            return;
        end
        case (ch)
            opl_pkg::CH_FF, opl_pkg::CH_NL: begin
                if (ch == opl_pkg::CH_FF)
                    line_no = plen_cfg;
                if (rows_used == 0)
                    rows_used = 1;
                print_line(ch);
            end
            opl_pkg::CH_BS: begin
                if (column <= indent_cfg)
                    column = indent_cfg;
                else
                    column--;
            end
            opl_pkg::CH_CR: begin
                column = indent_cfg;
            end
            opl_pkg::CH_TAB: begin
                d = (column >= indent_cfg) ? column - indent_cfg : 0;
                move_to((d | int'(opl_pkg::TAB_MASK)) + indent_cfg + 1);
            end
            default: begin
                strike(ch);
            end
        endcase
    endfunction

    function automatic void stream_end();
        if (rows_used > 0)
            print_line(opl_pkg::CH_NL);
        if (line_no != 0) begin
            put_byte(opl_pkg::CH_FF);
            page_no = page_no + 16'd1;
        end
        put_byte(opl_pkg::CH_ESC);
        put_byte(opl_pkg::CH_RESET);
        line_no = 0;
        esc_state = opl_pkg::ESC_IDLE;
        prev_str = 8'd0;
        lead_skip = 1;
        column = indent_cfg;
    endfunction

    function automatic void printer_reset();
        width_cfg = int'(opl_pkg::LINE_WIDTH_RST);
        plen_cfg = int'(opl_pkg::PAGE_LENGTH_RST);
        indent_cfg = 0;
        literal_cfg = 0;
        for (int r = 0; r < opl_pkg::LAYERS_DEF; r++) begin
            row_len[r] = 0;
            for (int c = 0; c < opl_pkg::LINE_WIDTH_DEF; c++)
                shadow_rows[r][c] = opl_pkg::CH_SPACE;
        end
        column = 0;
        rows_used = 0;
        line_no = 0;
        page_no = 16'd0;
        esc_state = opl_pkg::ESC_IDLE;
        prev_str = 8'd0;
        lead_skip = 1;
    endfunction

    // Runs one item through the model and, when queue_them is set, queues the chunks that it causes.
    function automatic void predict_chunks(logic [7:0] data, logic eos, bit queue_them);
        int     n;
        int     parts;
        t_chunk ch;
        printer_bytes.delete();
        if (eos)
            stream_end();
        else
            text_step(data);
        n = printer_bytes.size();
        parts = (n + opl_pkg::RESULT_BYTES - 1) / opl_pkg::RESULT_BYTES;
        for (int k = 0; k < parts && queue_them; k++) begin
            ch.bytes = '0;
            ch.count = 6'((n - k * opl_pkg::RESULT_BYTES < opl_pkg::RESULT_BYTES) ?
                          n - k * opl_pkg::RESULT_BYTES : opl_pkg::RESULT_BYTES);
            for (int j = 0; j < ch.count; j++)
                ch.bytes[j*8 +: 8] = printer_bytes[k * opl_pkg::RESULT_BYTES + j];
            ch.last = (k + 1 == parts);
            ch.pages = page_no;
            pending_chunks.push_back(ch);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("overstrike_print_line_filter test failed");
                $finish;
            end
        end
    end

    // Register writes happen only while the block is idle, so the model takes
    // them at once. The write enable is dropped by the caller after the last one.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            opl_pkg::REG_LINE_WIDTH:  width_cfg = int'(val);
            opl_pkg::REG_PAGE_LENGTH: plen_cfg = int'(val);
            opl_pkg::REG_INDENT: begin
                indent_cfg = int'(val);
                column = indent_cfg;
            end
            opl_pkg::REG_LITERAL:     literal_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic set_printer(int wid, int plen, int ind, bit lit);
        write_reg(opl_pkg::REG_LINE_WIDTH, 8'(wid));
        write_reg(opl_pkg::REG_PAGE_LENGTH, 8'(plen));
        write_reg(opl_pkg::REG_INDENT, 8'(ind));
        write_reg(opl_pkg::REG_LITERAL, {7'd0, lit});
        i_cfg_we <= 1'b0;
    endtask

    // Offers one item and holds it until the transfer. Called at a rising edge;
    // returns at a rising edge after the sender's own gap.
    task automatic send_item(logic [7:0] data, logic eos, bit model_it);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tlast <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (model_it)
            predict_chunks(data, eos, 1);
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender pause: let every expected chunk drain, then give a byte that sends
    // nothing time to finish before any register changes.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_chunks.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random text with well-formed escape and device-control sequences mixed in,
    // plus some broken ones and raw noise.
    task automatic make_text(int n);
        int r;
        int len;
        text_q.delete();
        while (text_q.size() < n) begin
            r = $urandom_range(0, 99);
            if (r < 42)
                text_q.push_back('{8'($urandom_range(8'h21, 8'h7E)), 1'b0});
            else if (r < 49)
                text_q.push_back('{opl_pkg::CH_SPACE, 1'b0});
            else if (r < 58)
                text_q.push_back('{opl_pkg::CH_BS, 1'b0});
            else if (r < 63)
                text_q.push_back('{opl_pkg::CH_CR, 1'b0});
            else if (r < 68)
                text_q.push_back('{opl_pkg::CH_TAB, 1'b0});
            else if (r < 76)
                text_q.push_back('{opl_pkg::CH_NL, 1'b0});
            else if (r < 78)
                text_q.push_back('{opl_pkg::CH_FF, 1'b0});
            else if (r < 84) begin
                text_q.push_back('{opl_pkg::CH_ESC, 1'b0});
                len = $urandom_range(0, 4);
                if ($urandom_range(0, 1)) begin
                    text_q.push_back('{opl_pkg::CH_UPPER_P, 1'b0});
                    repeat (len) text_q.push_back('{8'($urandom()), 1'b0});
                    if ($urandom_range(0, 5) != 0) begin
                        text_q.push_back('{opl_pkg::CH_ESC, 1'b0});
                        text_q.push_back('{opl_pkg::CH_BSLASH, 1'b0});
                    end
                end else begin
                    text_q.push_back('{opl_pkg::CH_BRACKET, 1'b0});
                    repeat (len) text_q.push_back('{8'($urandom_range(8'h30, 8'h3F)), 1'b0});
                    if ($urandom_range(0, 5) != 0)
                        text_q.push_back('{8'($urandom_range(8'h40, 8'h7E)), 1'b0});
                end
            end else if (r < 91)
                text_q.push_back('{8'($urandom_range(8'h80, 8'hFF)), 1'b0});
            else if (r < 93)
                text_q.push_back('{opl_pkg::CH_NUL, 1'b0});
            else if (r < 96)
                text_q.push_back('{8'($urandom()), 1'b1});
            else
                text_q.push_back('{8'($urandom()), 1'b0});
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    t_table_row rows[$];

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= opl_pkg::REG_LINE_WIDTH;
        i_cfg_wdata <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'd0;
        s_axis_tlast <= 1'b0;
        errors = 0;
        items_sent = 0;
        no_idle = 0;
        printer_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // End of an empty stream gives only the ESC 'c' trailer. A lone newline
        // sends just itself; ending after it closes the partly used page.
        rows.push_back('{8'h00, 1'b1, 1'b1, 256'h631B, 6'd2, 16'd0});
        rows.push_back('{opl_pkg::CH_NL, 1'b0, 1'b1, 256'h0A, 6'd1, 16'd0});
        rows.push_back('{8'hFF, 1'b1, 1'b1, 256'h631B0C, 6'd3, 16'd1});
        // Form feed and NUL are skipped at the start of a stream.
        rows.push_back('{opl_pkg::CH_FF, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_NUL, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        // Overstrike, column moves and control bytes in a line.
        rows.push_back('{8'h41, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_BS, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h5F, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_TAB, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h7F, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h80, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'hFF, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_CR, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h42, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        // A control sequence ending on its final byte, then a device string.
        rows.push_back('{opl_pkg::CH_ESC, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_BRACKET, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h31, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h6D, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_ESC, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_UPPER_P, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h78, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_ESC, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_BSLASH, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_NL, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{opl_pkg::CH_FF, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        // The stream ends in the middle of an escape.
        rows.push_back('{opl_pkg::CH_ESC, 1'b0, 1'b0, '0, 6'd0, 16'd0});
        rows.push_back('{8'h00, 1'b1, 1'b0, '0, 6'd0, 16'd0});

        // A typed-in chunk is queued before its item goes out, so it is waiting
        // before the block can answer.
        foreach (rows[i]) begin
            if (rows[i].known) begin
                predict_chunks(rows[i].data, rows[i].eos, 0);
                pending_chunks.push_back('{rows[i].exp_bytes, rows[i].exp_count, 1'b1,
                                           rows[i].exp_pages});
                send_item(rows[i].data, rows[i].eos, 0);
            end else begin
                send_item(rows[i].data, rows[i].eos, 1);
            end
        end
        drain();

        // Random phases. The first three use fixed settings, mostly at the register extremes; the rest pick
        // settings at random, mostly narrow lines so that rows fill and overstrike.
        for (int ph = 0; ph < RAND_PHASES + 3; ph++) begin
            case (ph)
                0: set_printer(132, 1, 0, 1);
                1: set_printer(1, 255, 131, 0);
                2: set_printer(8, 3, 2, 1);
                default: set_printer($urandom_range(1, 24), $urandom_range(1, 80),
                                     $urandom_range(0, 6), 1'($urandom_range(0, 1)));
            endcase
            no_idle = (ph % 3 == 1);
            make_text(ITEMS_PER_PHASE / 2 + (ph >= 3 ? ITEMS_PER_PHASE / 2 : 0));
            foreach (text_q[i])
                send_item(text_q[i].data, text_q[i].eos, 1);
            send_item(8'h00, 1'b1, 1);
            drain();
        end

        // Back to the reset settings before the end.
        set_printer(int'(opl_pkg::LINE_WIDTH_RST), int'(opl_pkg::PAGE_LENGTH_RST), 0, 0);
        send_item(8'h41, 1'b0, 1);
        send_item(8'h00, 1'b1, 1);
        drain();

        $display("Sent %0d text items over %0d register settings; checked %0d output chunks.",
                 items_sent, RAND_PHASES + 5, chunks_seen);
        $display("Covered overstrike rows, column moves, escape strings and page ends.");
        if (errors == 0) begin
            $display("overstrike_print_line_filter test passed");
        end else begin
            $display("overstrike_print_line_filter test failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // Each transfer on the result side is checked against the oldest pending
    // chunk. Once, early in the run, the receiver holds off for a long stretch
    // so the block backs up and stops taking input.
    initial begin
        string  names[4];
        t_chunk want;
        int     gap;
        names[0] = "bytes_0_7";
        names[1] = "bytes_8_15";
        names[2] = "bytes_16_23";
        names[3] = "bytes_24_31";
        chunks_seen = 0;
        m_axis_tready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            chunks_seen++;
            if (pending_chunks.size() == 0) begin
                $error("unexpected transfer on the result side");
                errors++;
            end else begin
                want = pending_chunks.pop_front();
                for (int s = 0; s < 4; s++)
                    if (m_axis_tdata[s*64 +: 64] !== want.bytes[s*64 +: 64]) begin
                        $error("%s: expected %h, got %h", names[s],
                               want.bytes[s*64 +: 64], m_axis_tdata[s*64 +: 64]);
                        errors++;
                    end
                if (m_axis_tdata[261:256] !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[261:256]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[277:262] !== want.pages) begin
                    $error("pages_done: expected %0d, got %0d", want.pages,
                           m_axis_tdata[277:262]);
                    errors++;
                end
            end
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (chunks_seen == 40)
                gap = 600;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

endmodule

[files.f]
rtl/core/opl_pkg.sv
rtl/core/opl_ctrl.sv
rtl/core/opl_dp.sv
rtl/core/overstrike_print_line_filter.sv
sim/tb_overstrike_print_line_filter.sv
